// File: sv/u8n1_pkg.sv
// shared types, codes and constants of the half-duplex 8n1 uart
package u8n1_pkg;

  localparam int DATA_BITS    = 8;
  localparam int COUNTER_BITS = 16;
  localparam int FRAME_BITS   = DATA_BITS + 2;
  localparam int BITS_W       = 4;

  localparam logic [COUNTER_BITS-1:0] PERIOD_RESET = COUNTER_BITS'(104);
  localparam logic [COUNTER_BITS-1:0] PERIOD_MIN   = COUNTER_BITS'(4);

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_TAKE = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_TX   = 2'd2;

  typedef struct packed {
    logic                 tx_line;
    logic                 send_accepted;
    logic [DATA_BITS-1:0] received_data;
    logic                 received_valid;
    logic                 byte_ready;
    logic                 busy_receiving;
    logic                 busy_sending;
  } res_t;

endpackage

// File: sv/u8n1_in_if.sv
// input channel: one tick item with command, receive level and send byte
interface u8n1_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic                          rx_level;
  logic [u8n1_pkg::DATA_BITS-1:0] send_data;

  modport source (output valid, output command, output rx_level, output send_data,
                  input ready);
  modport sink (input valid, input command, input rx_level, input send_data,
                output ready);
endinterface

// File: sv/u8n1_out_if.sv
// result channel: line level and status after each tick
interface u8n1_out_if;
  logic                          valid;
  logic                          ready;
  logic                          tx_line;
  logic                          send_accepted;
  logic [u8n1_pkg::DATA_BITS-1:0] received_data;
  logic                          received_valid;
  logic                          byte_ready;
  logic                          busy_receiving;
  logic                          busy_sending;

  modport source (output valid, output tx_line, output send_accepted,
                  output received_data, output received_valid, output byte_ready,
                  output busy_receiving, output busy_sending, input ready);
  modport sink (input valid, input tx_line, input send_accepted,
                input received_data, input received_valid, input byte_ready,
                input busy_receiving, input busy_sending, output ready);
endinterface

// File: sv/u8n1_engine.sv
// uart state, shared bit timer and per-tick next-state and result logic
module u8n1_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [1:0]                          command,
  input  logic                                rx_level,
  input  logic [u8n1_pkg::DATA_BITS-1:0]      send_data,
  input  logic                                cfg_we,
  input  logic [u8n1_pkg::COUNTER_BITS-1:0]   cfg_data,
  output u8n1_pkg::res_t                      res
);

  localparam int CW = u8n1_pkg::COUNTER_BITS;
  localparam int DW = u8n1_pkg::DATA_BITS;
  localparam int FW = u8n1_pkg::FRAME_BITS;
  localparam int BW = u8n1_pkg::BITS_W;

  logic [CW-1:0] period_r;
  logic [1:0]    mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] bits_r, bits_nxt;
  logic [FW-1:0] tx_sh_r, tx_sh_nxt;
  logic [FW-1:0] rx_sh_r, rx_sh_nxt;
  logic [DW-1:0] held_r, held_nxt;
  logic          rdy_r, rdy_nxt;
  logic          prev_rx_r, prev_rx_nxt;
  logic          line_r, line_nxt;

  logic [CW-1:0] period;
  logic [CW-1:0] period_m1;
  logic [CW-1:0] half_m1;
  logic [FW-1:0] rx_shifted;
  logic          accepted;
  logic          taken;

  always_comb begin
    period    = (period_r < u8n1_pkg::PERIOD_MIN) ? u8n1_pkg::PERIOD_MIN : period_r;
    period_m1 = period - CW'(1);
    half_m1   = (period >> 1) - CW'(1);
    rx_shifted = {rx_level, rx_sh_r[FW-1:1]};

    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    bits_nxt    = bits_r;
    tx_sh_nxt   = tx_sh_r;
    rx_sh_nxt   = rx_sh_r;
    held_nxt    = held_r;
    rdy_nxt     = rdy_r;
    line_nxt    = line_r;
    prev_rx_nxt = rx_level;
    accepted    = 1'b0;
    taken       = 1'b0;

    // take acts before a frame end in the same tick
    if (command == u8n1_pkg::CMD_TAKE && rdy_r) begin
      taken   = 1'b1;
      rdy_nxt = 1'b0;
    end

    unique case (mode_r)
      u8n1_pkg::MODE_TX: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CW'(1);
        end else if (bits_r == '0) begin
          mode_nxt = u8n1_pkg::MODE_IDLE;
          line_nxt = 1'b1;
        end else begin
          line_nxt  = tx_sh_r[0];
          tx_sh_nxt = {1'b0, tx_sh_r[FW-1:1]};
          bits_nxt  = bits_r - BW'(1);
          cnt_nxt   = period_m1;
        end
      end
      u8n1_pkg::MODE_RX: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          rx_sh_nxt = rx_shifted;
          bits_nxt  = bits_r - BW'(1);
          cnt_nxt   = period_m1;
          if (bits_r == BW'(1)) begin
            mode_nxt = u8n1_pkg::MODE_IDLE;
            // keep the frame only with a low start and a high stop sample
            if (!rx_shifted[0] && rx_shifted[FW-1]) begin
              held_nxt = rx_shifted[DW:1];
              rdy_nxt  = 1'b1;
            end
          end
        end
      end
      default: begin
        if (command == u8n1_pkg::CMD_SEND) begin
          accepted  = 1'b1;
          mode_nxt  = u8n1_pkg::MODE_TX;
          line_nxt  = 1'b0;
          tx_sh_nxt = {1'b0, 1'b1, send_data};
          bits_nxt  = BW'(DW + 1);
          cnt_nxt   = period_m1;
        end else if (prev_rx_r && !rx_level) begin
          mode_nxt  = u8n1_pkg::MODE_RX;
          rx_sh_nxt = '0;
          bits_nxt  = BW'(FW);
          cnt_nxt   = half_m1;
        end
      end
    endcase

    res.tx_line        = line_nxt;
    res.send_accepted  = accepted;
    res.received_data  = taken ? held_r : held_nxt;
    res.received_valid = taken;
    res.byte_ready     = rdy_nxt;
    res.busy_receiving = (mode_nxt == u8n1_pkg::MODE_RX);
    res.busy_sending   = (mode_nxt == u8n1_pkg::MODE_TX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= u8n1_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= u8n1_pkg::MODE_IDLE;
      cnt_r     <= '0;
      bits_r    <= '0;
      tx_sh_r   <= '1;
      rx_sh_r   <= '0;
      held_r    <= '0;
      rdy_r     <= 1'b0;
      prev_rx_r <= 1'b1;
      line_r    <= 1'b1;
    end else if (step) begin
      mode_r    <= mode_nxt;
      cnt_r     <= cnt_nxt;
      bits_r    <= bits_nxt;
      tx_sh_r   <= tx_sh_nxt;
      rx_sh_r   <= rx_sh_nxt;
      held_r    <= held_nxt;
      rdy_r     <= rdy_nxt;
      prev_rx_r <= prev_rx_nxt;
      line_r    <= line_nxt;
    end
  end

endmodule

// File: sv/u8n1_out_reg.sv
// result register that parts the input side from a stalled receiver
module u8n1_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  u8n1_pkg::res_t in_res,
  output logic           out_valid,
  input  logic           out_ready,
  output u8n1_pkg::res_t out_res
);

  logic           valid_r;
  u8n1_pkg::res_t res_r;

  // refill in the same cycle the held result is taken
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= in_res;
    end
  end

endmodule

// File: sv/uart_8n1_half_duplex.sv
// top level of the half-duplex 8n1 uart with one shared bit timer
//
// each transfer on in_ch is one clock tick of the serial side: a command
// (tick, send, take), the sampled receive level and the byte to send.
// every input transfer yields exactly one result on out_ch: the transmit
// line level, send and take acknowledges, the held byte and busy flags,
// all as they stand after that tick.
// the result is registered and offered in the cycle after the input
// transfer. throughput is one item per cycle while out_ch takes results;
// the single result register lets a new item in during the same cycle
// the waiting result is taken.
// if out_ch stalls, in_ch.ready drops once the result register is full and
// the uart state holds still, so no tick is lost or repeated.
// cfg_we writes cfg_data to the bit period (ticks per bit, values below 4
// act as 4); write it only while no item is in flight.
// synchronous reset clears the state at once: idle, line high, no byte
// ready, held byte zero, bit period 104. no clearing pass follows.
module uart_8n1_half_duplex (
  input  logic                              clk,
  input  logic                              rst_n,
  u8n1_in_if.sink                           in_ch,
  u8n1_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [u8n1_pkg::COUNTER_BITS-1:0] cfg_data
);

  u8n1_pkg::res_t res;
  u8n1_pkg::res_t res_q;
  logic           in_ready;
  logic           step;

  assign in_ch.ready = in_ready;
  assign step        = in_ch.valid && in_ready;

  u8n1_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .command   (in_ch.command),
    .rx_level  (in_ch.rx_level),
    .send_data (in_ch.send_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  u8n1_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_res    (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res_q)
  );

  assign out_ch.tx_line        = res_q.tx_line;
  assign out_ch.send_accepted  = res_q.send_accepted;
  assign out_ch.received_data  = res_q.received_data;
  assign out_ch.received_valid = res_q.received_valid;
  assign out_ch.byte_ready     = res_q.byte_ready;
  assign out_ch.busy_receiving = res_q.busy_receiving;
  assign out_ch.busy_sending   = res_q.busy_sending;

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the half-duplex 8n1 uart: directed frames, random traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [u8n1_pkg::COUNTER_BITS-1:0] cfg_data;

  u8n1_in_if  in_ch();
  u8n1_out_if out_ch();

  uart_8n1_half_duplex uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5ns clk = ~clk;

  // predicted uart state
  logic [u8n1_pkg::COUNTER_BITS-1:0] bit_period_q;
  logic [1:0]                        mode_q;
  logic [u8n1_pkg::COUNTER_BITS-1:0] timer_q;
  logic [u8n1_pkg::BITS_W-1:0]       bits_left_q;
  logic [u8n1_pkg::FRAME_BITS-1:0]   tx_shift_q;
  logic [u8n1_pkg::FRAME_BITS-1:0]   rx_shift_q;
  logic [u8n1_pkg::DATA_BITS-1:0]    held_q;
  logic                              ready_q;
  logic                              prev_rx_q;
  logic                              line_q;

  u8n1_pkg::res_t status_due_q[$];
  u8n1_pkg::res_t want;
  int   mismatches = 0;
  int   ticks_sent = 0;
  int   in_gap_pct = 0;
  int   out_stall_pct = 0;
  int   idle_cycles = 0;

  task automatic reset_prediction();
    bit_period_q = u8n1_pkg::PERIOD_RESET;
    mode_q       = u8n1_pkg::MODE_IDLE;
    timer_q      = '0;
    bits_left_q  = '0;
    tx_shift_q   = '1;
    rx_shift_q   = '0;
    held_q       = '0;
    ready_q      = 1'b0;
    prev_rx_q    = 1'b1;
    line_q       = 1'b1;
  endtask

  function automatic logic [u8n1_pkg::COUNTER_BITS-1:0] eff_period();
    return (bit_period_q < u8n1_pkg::PERIOD_MIN) ? u8n1_pkg::PERIOD_MIN : bit_period_q;
  endfunction

  // one tick of the serial side, returns the status after it
  function automatic u8n1_pkg::res_t step_uart(input logic [1:0] cmd, input logic rx,
                                               input logic [u8n1_pkg::DATA_BITS-1:0] data);
    u8n1_pkg::res_t r;
    logic [u8n1_pkg::COUNTER_BITS-1:0] per;
    logic [1:0] start_mode;
    logic [u8n1_pkg::DATA_BITS-1:0] taken;
    per = eff_period();
    start_mode = mode_q;
    taken = '0;
    r = '0;
    if (cmd == u8n1_pkg::CMD_TAKE && ready_q) begin
      r.received_valid = 1'b1;
      taken = held_q;
      ready_q = 1'b0;
    end
    case (start_mode)
      u8n1_pkg::MODE_TX: begin
        if (timer_q != '0) begin
          timer_q = timer_q - 1'b1;
        end else if (bits_left_q == '0) begin
          mode_q = u8n1_pkg::MODE_IDLE;
          line_q = 1'b1;
        end else begin
          line_q = tx_shift_q[0];
          tx_shift_q = tx_shift_q >> 1;
          bits_left_q = bits_left_q - 1'b1;
          timer_q = per - 1'b1;
        end
      end
      u8n1_pkg::MODE_RX: begin
        if (timer_q != '0) begin
          timer_q = timer_q - 1'b1;
        end else begin
          rx_shift_q = {rx, rx_shift_q[u8n1_pkg::FRAME_BITS-1:1]};
          bits_left_q = bits_left_q - 1'b1;
          timer_q = per - 1'b1;
          if (bits_left_q == '0) begin
            mode_q = u8n1_pkg::MODE_IDLE;
            if (!rx_shift_q[0] && rx_shift_q[u8n1_pkg::FRAME_BITS-1]) begin
              held_q = rx_shift_q[u8n1_pkg::DATA_BITS:1];
              ready_q = 1'b1;
            end
          end
        end
      end
      default: begin
        if (cmd == u8n1_pkg::CMD_SEND) begin
          r.send_accepted = 1'b1;
          mode_q = u8n1_pkg::MODE_TX;
          line_q = 1'b0;
          tx_shift_q = {2'b01, data};
          bits_left_q = u8n1_pkg::BITS_W'(u8n1_pkg::DATA_BITS + 1);
          timer_q = per - 1'b1;
        end else if (prev_rx_q && !rx) begin
          mode_q = u8n1_pkg::MODE_RX;
          rx_shift_q = '0;
          bits_left_q = u8n1_pkg::BITS_W'(u8n1_pkg::FRAME_BITS);
          timer_q = (per >> 1) - 1'b1;
        end
      end
    endcase
    prev_rx_q = rx;
    r.tx_line = line_q;
    r.received_data = r.received_valid ? taken : held_q;
    r.byte_ready = ready_q;
    r.busy_receiving = (mode_q == u8n1_pkg::MODE_RX);
    r.busy_sending = (mode_q == u8n1_pkg::MODE_TX);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_due_q.size() == 0) begin
        $display("%0t: status transfer with no prediction pending", $time);
        mismatches++;
      end else begin
        want = status_due_q.pop_front();
        check_field("tx_line", want.tx_line, out_ch.tx_line);
        check_field("send_accepted", want.send_accepted, out_ch.send_accepted);
        check_field("received_data", want.received_data, out_ch.received_data);
        check_field("received_valid", want.received_valid, out_ch.received_valid);
        check_field("byte_ready", want.byte_ready, out_ch.byte_ready);
        check_field("busy_receiving", want.busy_receiving, out_ch.busy_receiving);
        check_field("busy_sending", want.busy_sending, out_ch.busy_sending);
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // cycles without any transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("uart_8n1_half_duplex test failed");
    $finish;
  end

  task automatic push_tick(input logic [1:0] cmd, input logic rx,
                           input logic [u8n1_pkg::DATA_BITS-1:0] data);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.rx_level  <= rx;
    in_ch.send_data <= data;
    do @(posedge clk); while (!in_ch.ready);
    status_due_q.push_back(step_uart(cmd, rx, data));
    ticks_sent++;
    if ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
  endtask

  task automatic set_period(input logic [u8n1_pkg::COUNTER_BITS-1:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (status_due_q.size() != 0);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    bit_period_q = value;
  endtask

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 80) return u8n1_pkg::CMD_TICK;
    if (r < 88) return u8n1_pkg::CMD_TAKE;
    if (r < 94) return u8n1_pkg::CMD_SEND;
    return CMD_SPARE;
  endfunction

  // idle line until the uart is back in idle with the line high
  task automatic settle_line();
    do push_tick(u8n1_pkg::CMD_TICK, 1'b1, u8n1_pkg::DATA_BITS'($urandom));
    while (mode_q != u8n1_pkg::MODE_IDLE);
  endtask

  task automatic drive_frame(input logic [u8n1_pkg::DATA_BITS-1:0] value,
                             input bit bad_start, input bit bad_stop,
                             input bit take_at_stop, input bit busy_cmds);
    logic [u8n1_pkg::FRAME_BITS-1:0] levels;
    logic lvl;
    logic [1:0] cmd;
    int per;
    per = int'(eff_period());
    levels = {~bad_stop, value, 1'b0};
    for (int i = 0; i < u8n1_pkg::FRAME_BITS; i++) begin
      for (int k = 0; k < per; k++) begin
        lvl = levels[i];
        // glitch: start bit back high before its mid-bit sample
        if (i == 0 && bad_start && k > 0) lvl = 1'b1;
        if (take_at_stop && mode_q == u8n1_pkg::MODE_RX &&
            bits_left_q == u8n1_pkg::BITS_W'(1) && timer_q == '0)
          cmd = u8n1_pkg::CMD_TAKE;
        else if (busy_cmds && !(i == 0 && k == 0))
          cmd = pick_cmd();
        else
          cmd = u8n1_pkg::CMD_TICK;
        push_tick(cmd, lvl, u8n1_pkg::DATA_BITS'($urandom));
      end
    end
  endtask

  task automatic test_idle_commands();
    push_tick(u8n1_pkg::CMD_TAKE, 1'b1, 8'h00);
    push_tick(CMD_SPARE, 1'b1, 8'hFF);
    push_tick(u8n1_pkg::CMD_TICK, 1'b1, 8'h00);
  endtask

  task automatic test_send_reset_period();
    // send and start edge together: the send wins
    push_tick(u8n1_pkg::CMD_SEND, 1'b0, 8'hA5);
    push_tick(u8n1_pkg::CMD_SEND, 1'b1, 8'h5A);
    push_tick(u8n1_pkg::CMD_TICK, 1'b0, 8'h00);
    push_tick(u8n1_pkg::CMD_TAKE, 1'b1, 8'hFF);
    // run past the end of the start bit at the reset bit period
    repeat (110) push_tick(u8n1_pkg::CMD_TICK, 1'b1, 8'h00);
    set_period(u8n1_pkg::PERIOD_MIN);
    settle_line();
  endtask

  task automatic test_min_period();
    set_period('0);
    push_tick(u8n1_pkg::CMD_SEND, 1'b1, 8'hFF);
    settle_line();
    set_period(u8n1_pkg::COUNTER_BITS'(3));
    push_tick(u8n1_pkg::CMD_SEND, 1'b1, 8'h00);
    settle_line();
    set_period(u8n1_pkg::PERIOD_MIN);
  endtask

  task automatic test_receive_frames();
    settle_line();
    drive_frame(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(u8n1_pkg::CMD_TAKE, 1'b1, 8'h00);
    settle_line();
    drive_frame(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    settle_line();
    // take lands on the stop sample while the previous byte is still held
    drive_frame(8'h5A, 1'b0, 1'b0, 1'b1, 1'b0);
    settle_line();
    drive_frame(8'h3C, 1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(u8n1_pkg::CMD_TAKE, 1'b1, 8'h00);
    push_tick(u8n1_pkg::CMD_TAKE, 1'b1, 8'h00);
  endtask

  task automatic test_bad_frames();
    settle_line();
    drive_frame(8'hA5, 1'b1, 1'b0, 1'b0, 1'b0);
    settle_line();
    drive_frame(8'hC3, 1'b0, 1'b1, 1'b0, 1'b0);
    settle_line();
    push_tick(u8n1_pkg::CMD_TAKE, 1'b1, 8'h00);
  endtask

  task automatic random_traffic(input int n);
    int stop_at;
    int pick;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        settle_line();
        drive_frame(u8n1_pkg::DATA_BITS'($urandom), ($urandom_range(9) == 0),
                    ($urandom_range(9) == 0), ($urandom_range(4) == 0), 1'b1);
        if ($urandom_range(1) == 1)
          push_tick(u8n1_pkg::CMD_TAKE, 1'b1, u8n1_pkg::DATA_BITS'($urandom));
      end else if (pick < 85) begin
        settle_line();
        push_tick(u8n1_pkg::CMD_SEND, 1'($urandom_range(1)), u8n1_pkg::DATA_BITS'($urandom));
        while (mode_q == u8n1_pkg::MODE_TX)
          push_tick(pick_cmd(), 1'($urandom_range(1)), u8n1_pkg::DATA_BITS'($urandom));
      end else begin
        repeat ($urandom_range(20, 5))
          push_tick(2'($urandom_range(3)), 1'($urandom_range(1)),
                    u8n1_pkg::DATA_BITS'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    in_gap_pct = 0;
    out_stall_pct = 0;
    random_traffic(110);
    set_period(u8n1_pkg::COUNTER_BITS'(5));
    in_gap_pct = 64;
    random_traffic(110);
    set_period(u8n1_pkg::COUNTER_BITS'(7));
    in_gap_pct = 0;
    out_stall_pct = 64;
    random_traffic(110);
    set_period(u8n1_pkg::COUNTER_BITS'(6));
    in_gap_pct = 37;
    out_stall_pct = 37;
    random_traffic(110);
  endtask

  task automatic test_max_period();
    in_gap_pct = 0;
    out_stall_pct = 0;
    set_period('1);
    push_tick(u8n1_pkg::CMD_SEND, 1'b1, 8'h81);
    repeat (20)
      push_tick(pick_cmd(), 1'($urandom_range(1)), u8n1_pkg::DATA_BITS'($urandom));
  endtask

  initial begin
    reset_prediction();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= u8n1_pkg::CMD_TICK;
    in_ch.rx_level  <= 1'b1;
    in_ch.send_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_commands();
    test_send_reset_period();
    test_min_period();
    test_receive_frames();
    test_bad_frames();
    test_random_phases();
    test_max_period();

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (status_due_q.size() != 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("uart_8n1_half_duplex test passed");
    end else begin
      $display("uart_8n1_half_duplex test failed");
    end
    $finish;
  end

endmodule
